// File: rtl/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants of the indexed list engine: list size, field
// widths, command and status codes and the control word of the cell row.
// ----------------------------------------------------------------------------
package ile_pkg;

  // list geometry
  localparam int CAPACITY    = 32;
  localparam int ENTRY_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  // fixed field widths of the stream words
  localparam int CMD_W   = 4;
  localparam int POS_W   = 6;
  localparam int WORD_W  = 32;
  localparam int STAT_W  = 3;
  localparam int FOUND_W = 5;
  localparam int COUNT_W = 6;

  localparam int IN_BITS  = CMD_W + POS_W + WORD_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = STAT_W + WORD_W + FOUND_W + COUNT_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef logic [ENTRY_WIDTH-1:0] entry_t;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH      = 4'd0,
    CMD_POP       = 4'd1,
    CMD_PREPEND   = 4'd2,
    CMD_DROP      = 4'd3,
    CMD_INSERT    = 4'd4,
    CMD_REMOVE    = 4'd5,
    CMD_GET       = 4'd6,
    CMD_SET       = 4'd7,
    CMD_PEEK      = 4'd8,
    CMD_FIND      = 4'd9,
    CMD_REMOVE_EQ = 4'd10,
    CMD_CLEAR     = 4'd11
  } cmd_t;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_MISSING = 3'd4
  } status_t;

  // operation that every cell carries out under the control word
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_REMOVE,
    OP_REMOVE_HIT,
    OP_WRITE
  } cell_op_t;

  // control word broadcast along the row
  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   at;
    logic [IDX_W-1:0]   rd_at;
    entry_t             word;
    logic               cmp_en;
    logic [CNT_W-1:0]   count;
  } cell_ctrl_t;

endpackage

// File: rtl/ile_cell.sv
// ----------------------------------------------------------------------------
// ile_cell
// One slot of the list: holds an entry, shifts towards either neighbour,
// compares against the search word and takes part in the first-match chain.
// ----------------------------------------------------------------------------
module ile_cell
  import ile_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  cell_ctrl_t       ctrl,
  input  entry_t           left_value,
  input  entry_t           right_value,
  input  logic             seen_in,
  output entry_t           value,
  output logic             seen_out,
  output logic             first,
  output entry_t           rd_data
);

  logic match;

  // first-match chain: a hit here or anywhere in front of this slot
  assign seen_out = seen_in | match;
  assign first    = match & ~seen_in;

  // read port, or-combined across the row
  assign rd_data = (idx == ctrl.rd_at) ? value : '0;

  // compare flag, only live slots take part
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctrl.cmp_en) begin
      match <= (CNT_W'(idx) < ctrl.count) && (value == ctrl.word);
    end
  end

  // entry update
  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      OP_INSERT: begin
        if (idx > ctrl.at) begin
          value <= left_value;
        end else if (idx == ctrl.at) begin
          value <= ctrl.word;
        end
      end
      OP_REMOVE: begin
        if (idx >= ctrl.at) begin
          value <= right_value;
        end
      end
      OP_REMOVE_HIT: begin
        if (seen_out) begin
          value <= right_value;
        end
      end
      OP_WRITE: begin
        if (idx == ctrl.at) begin
          value <= ctrl.word;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/indexed_list_engine.sv
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of up to CAPACITY words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_ stream, one word each; results leave on the
//   m_ stream, exactly one word per command, in order.
//   Each command passes the states S_IDLE, in which it is accepted, S_MATCH,
//   in which every cell compares its entry with the search word, and
//   S_EXEC, in which the first-match chain settles, the row shifts or
//   writes and the result is registered. A new command is taken only
//   once the engine is back in S_IDLE, since the compare and the ripple
//   of the first-match chain along the row each hold a state of their own.
//   The result register stands apart from the engine: a new command is
//   taken while an earlier result still waits. If the receiver stalls and
//   the result register is still full, the engine holds in its last cycle
//   and s_tready stays low until the result is taken.
//   Reset empties the list and drops any pending result; entry contents
//   are left as they are and are only read below the count.
// ----------------------------------------------------------------------------
module indexed_list_engine
  import ile_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // cmd[3:0], position[9:4], word_in[41:10], zero pad
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // status[2:0], word_out[34:3], found_index[39:35], count[45:40], zero pad
  output logic [OUT_W-1:0] m_tdata
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t           state, state_next;
  cmd_t             cmd_q;
  logic [POS_W-1:0] pos_q;
  entry_t           word_q;
  logic [CNT_W-1:0] item_count, item_count_next;

  cell_ctrl_t       ctrl;
  cell_op_t         op;
  logic [IDX_W-1:0] at;
  logic [IDX_W-1:0] rd_at;
  status_t          status_next;
  entry_t           rd_next;
  logic [IDX_W-1:0] hit_idx;
  logic             hit_any;
  entry_t           rd_word;
  logic             out_free;
  logic             fire;
  logic             full;
  logic             empty;
  logic             pos_gt;
  logic             pos_ge;

  entry_t           cell_value [CAPACITY];
  entry_t           cell_rd    [CAPACITY];
  logic [CAPACITY:0]    seen;
  logic [CAPACITY-1:0]  first;

  assign out_free = ~m_tvalid | m_tready;
  assign fire     = (state == S_EXEC) && out_free;
  assign s_tready = (state == S_IDLE) && !rst;

  // command capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_q  <= cmd_t'(s_tdata[CMD_W-1:0]);
      pos_q  <= s_tdata[CMD_W +: POS_W];
      word_q <= ENTRY_WIDTH'(s_tdata[CMD_W+POS_W +: WORD_W]);
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = S_MATCH;
      S_MATCH: state_next = S_EXEC;
      S_EXEC:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // list status
  assign full   = item_count >= CNT_W'(CAPACITY);
  assign empty  = item_count == '0;
  assign pos_gt = 32'(pos_q) > 32'(item_count);
  assign pos_ge = 32'(pos_q) >= 32'(item_count);

  // command decode
  always_comb begin
    status_next     = ST_OK;
    rd_next         = '0;
    item_count_next = item_count;
    op              = OP_HOLD;
    at              = IDX_W'(pos_q);
    rd_at           = (cmd_q == CMD_PEEK) ? IDX_W'(item_count - CNT_W'(1)) : IDX_W'(pos_q);
    unique case (cmd_q)
      CMD_PUSH: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          op              = OP_WRITE;
          at              = IDX_W'(item_count);
          item_count_next = item_count + CNT_W'(1);
        end
      end
      CMD_POP: begin
        if (empty) status_next = ST_EMPTY;
        else item_count_next = item_count - CNT_W'(1);
      end
      CMD_PREPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          op              = OP_INSERT;
          at              = '0;
          item_count_next = item_count + CNT_W'(1);
        end
      end
      CMD_DROP: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          op              = OP_REMOVE;
          at              = '0;
          item_count_next = item_count - CNT_W'(1);
        end
      end
      CMD_INSERT: begin
        if (pos_gt) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          op              = OP_INSERT;
          item_count_next = item_count + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (pos_ge) begin
          status_next = ST_RANGE;
        end else begin
          op              = OP_REMOVE;
          item_count_next = item_count - CNT_W'(1);
        end
      end
      CMD_GET: begin
        if (pos_ge) status_next = ST_RANGE;
        else rd_next = rd_word;
      end
      CMD_SET: begin
        if (pos_ge) status_next = ST_RANGE;
        else op = OP_WRITE;
      end
      CMD_PEEK: begin
        if (empty) status_next = ST_EMPTY;
        else rd_next = rd_word;
      end
      CMD_FIND: begin
        if (!hit_any) status_next = ST_MISSING;
      end
      CMD_REMOVE_EQ: begin
        if (!hit_any) begin
          status_next = ST_MISSING;
        end else begin
          op              = OP_REMOVE_HIT;
          item_count_next = item_count - CNT_W'(1);
        end
      end
      CMD_CLEAR: item_count_next = '0;
      default: begin
      end
    endcase
  end

  // row control word
  always_comb begin
    ctrl.op     = fire ? op : OP_HOLD;
    ctrl.at     = at;
    ctrl.rd_at  = rd_at;
    ctrl.word   = word_q;
    ctrl.cmp_en = (state == S_MATCH);
    ctrl.count  = item_count;
  end

  // row of cells
  assign seen[0] = 1'b0;
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_v, right_v;
    if (i == 0) begin : g_head
      assign left_v = cell_value[i];
    end else begin : g_body_l
      assign left_v = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = cell_value[i];
    end else begin : g_body_r
      assign right_v = cell_value[i+1];
    end
    ile_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .idx         (IDX_W'(i)),
      .ctrl        (ctrl),
      .left_value  (left_v),
      .right_value (right_v),
      .seen_in     (seen[i]),
      .value       (cell_value[i]),
      .seen_out    (seen[i+1]),
      .first       (first[i]),
      .rd_data     (cell_rd[i])
    );
  end

  assign hit_any = seen[CAPACITY];

  // read data and matched index, or-combined over the row
  always_comb begin
    rd_word = '0;
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
      hit_idx = hit_idx | (first[i] ? IDX_W'(i) : '0);
    end
  end

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_count <= '0;
    end else if (fire) begin
      item_count <= item_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= OUT_W'({COUNT_W'(item_count_next),
                         ((cmd_q == CMD_FIND || cmd_q == CMD_REMOVE_EQ) && hit_any)
                           ? FOUND_W'(hit_idx) : FOUND_W'(0),
                         WORD_W'(rd_next),
                         STAT_W'(status_next)});
    end
  end

  // a captured command always goes to the compare cycle next
  a_accept_match: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_MATCH))
    else $error("accepted command did not start compare");

  // the count only moves when a command completes
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(item_count))
    else $error("count changed outside a completing command");

  // the result word carries the count left by its command
  a_result_count: assert property (@(posedge clk) disable iff (rst)
    fire |=> (m_tvalid && m_tdata[STAT_W+WORD_W+FOUND_W +: COUNT_W] == COUNT_W'(item_count)))
    else $error("result count does not match list count");

  // the list never holds more than its capacity
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    fire |-> (item_count_next <= CNT_W'(CAPACITY)))
    else $error("list count above capacity");

endmodule
